>>> hw/rtl/hbsd_pkg.sv
// Shared types and constants of the bit-serial Huffman decoder.
`timescale 1ns / 1ps

package hbsd_pkg;

  localparam int unsigned SymW          = 8;
  localparam int unsigned LenW          = 6;
  localparam int unsigned CodeW         = 32;
  localparam int unsigned CodeIdxW      = 5;
  localparam int unsigned IdxW          = 8;
  localparam int unsigned SegCells      = 16;
  localparam int unsigned DefTableDepth = 256;
  localparam int unsigned DefMaxCodeLen = 32;

  localparam logic [SymW-1:0] EndMarker  = 8'h00;
  localparam logic            KindSymbol = 1'b0;
  localparam logic            KindError  = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_DECODE  = 2'd1,
    OP_RESTART = 2'd2
  } hbsd_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } hbsd_state_e;

  typedef struct packed {
    logic load;
    logic restart;
    logic step;
    logic code_bit;
  } hbsd_cmd_t;

  typedef struct packed {
    logic [IdxW-1:0]  slot;
    logic [SymW-1:0]  symbol;
    logic [LenW-1:0]  length;
    logic [CodeW-1:0] code;
    logic             alive;
  } hbsd_load_t;

  typedef struct packed {
    logic            reach;
    logic            ext;
    logic            exact;
    logic [SymW-1:0] symbol;
  } hbsd_carry_t;

endpackage

>>> hw/rtl/hbsd_cell.sv
// One code table entry with its path-match flag and its link in the match chain.
`timescale 1ns / 1ps

module hbsd_cell import hbsd_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = DefMaxCodeLen,
  parameter int unsigned CELL_INDEX   = 0,
  localparam int unsigned PlenW       = $clog2(MAX_CODE_LEN)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hbsd_cmd_t        cmd_i,
  input  hbsd_load_t       load_i,
  input  logic [PlenW-1:0] plen_i,
  input  logic [IdxW-1:0]  used_i,
  input  hbsd_carry_t      carry_i,
  output hbsd_carry_t      carry_o
);

  logic [SymW-1:0]  sym_q;
  logic [LenW-1:0]  len_q;
  logic [CodeW-1:0] code_q;
  logic             alive_q, alive_d;
  logic [LenW:0]    len_x, plen_x, step_x, pos;
  logic             wr, deeper, code_hi, bit_ok, in_use, live, exact, ext;

  assign wr      = cmd_i.load && (load_i.slot == IdxW'(CELL_INDEX));
  assign len_x   = {1'b0, len_q};
  assign plen_x  = (LenW + 1)'(plen_i);
  assign step_x  = plen_x + 1'b1;
  assign deeper  = len_x > plen_x;
  assign pos     = len_x - step_x;
  assign code_hi = (pos < (LenW + 1)'(CodeW)) ? code_q[pos[CodeIdxW-1:0]] : 1'b0;
  assign bit_ok  = deeper && (code_hi == cmd_i.code_bit);

  always_comb begin
    if (wr) begin
      alive_d = load_i.alive;
    end else if (cmd_i.restart) begin
      alive_d = 1'b1;
    end else if (cmd_i.step) begin
      alive_d = alive_q && bit_ok;
    end else begin
      alive_d = alive_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= 1'b1;
    end else begin
      alive_q <= alive_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      sym_q  <= load_i.symbol;
      len_q  <= load_i.length;
      code_q <= load_i.code;
    end
  end

  assign in_use = (IdxW + 1)'(CELL_INDEX) < {1'b0, used_i};
  assign live   = alive_q && in_use && (len_q != '0) &&
                  (len_x <= (LenW + 1)'(MAX_CODE_LEN));
  assign exact  = live && (len_x == step_x);
  assign ext    = live && (len_x > step_x);

  always_comb begin
    carry_o.reach  = carry_i.reach || exact || ext;
    carry_o.ext    = carry_i.ext || ext;
    carry_o.exact  = carry_i.exact || exact;
    carry_o.symbol = carry_i.exact ? carry_i.symbol : (exact ? sym_q : '0);
  end

endmodule

>>> hw/rtl/hbsd_row.sv
// Row of table cells in registered segments and the merge of the segment results.
`timescale 1ns / 1ps

module hbsd_row import hbsd_pkg::*; #(
  parameter int unsigned TABLE_DEPTH  = DefTableDepth,
  parameter int unsigned MAX_CODE_LEN = DefMaxCodeLen,
  localparam int unsigned PlenW       = $clog2(MAX_CODE_LEN)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hbsd_cmd_t        cmd_i,
  input  hbsd_load_t       load_i,
  input  logic [PlenW-1:0] plen_i,
  input  logic [IdxW-1:0]  used_i,
  input  logic             scan_i,
  output hbsd_carry_t      result_o
);

  localparam int unsigned NSeg = (TABLE_DEPTH + SegCells - 1) / SegCells;

  hbsd_carry_t chain [NSeg][SegCells+1];
  hbsd_carry_t seg_q [NSeg];

  for (genvar s = 0; s < NSeg; s++) begin : g_seg
    assign chain[s][0] = '0;
    for (genvar c = 0; c < SegCells; c++) begin : g_cell
      if (s * SegCells + c < TABLE_DEPTH) begin : g_on
        hbsd_cell #(
          .MAX_CODE_LEN(MAX_CODE_LEN),
          .CELL_INDEX  (s * SegCells + c)
        ) u_cell (
          .clk_i  (clk_i),
          .rst_ni (rst_ni),
          .cmd_i  (cmd_i),
          .load_i (load_i),
          .plen_i (plen_i),
          .used_i (used_i),
          .carry_i(chain[s][c]),
          .carry_o(chain[s][c+1])
        );
      end else begin : g_off
        assign chain[s][c+1] = chain[s][c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_i) begin
      for (int s = 0; s < NSeg; s++) begin
        seg_q[s] <= chain[s][SegCells];
      end
    end
  end

  always_comb begin
    hbsd_carry_t acc;
    acc = '0;
    for (int s = 0; s < NSeg; s++) begin
      if (!acc.exact && seg_q[s].exact) begin
        acc.symbol = seg_q[s].symbol;
      end
      acc.reach = acc.reach || seg_q[s].reach;
      acc.ext   = acc.ext || seg_q[s].ext;
      acc.exact = acc.exact || seg_q[s].exact;
    end
    result_o = acc;
  end

endmodule

>>> hw/rtl/huffman_bit_serial_decoder.sv
// Bit-serial Huffman decoder: top level with control, partial code and output register.
// A decode item runs in steps: the cells update their path flags at acceptance, the
// segment results are registered in ST_SCAN, then in ST_DONE the merge decides and writes
// the output register, waiting while that register holds a result and is stalled. Load and
// restart items complete at acceptance; no new item is taken until a decode is done.
// Reset clears the partial code, the error hold and the entry count; table entries are
// undefined until loaded, and no clearing pass runs after reset.
`timescale 1ns / 1ps

module huffman_bit_serial_decoder import hbsd_pkg::*; #(
  parameter int unsigned TABLE_DEPTH  = DefTableDepth,
  parameter int unsigned MAX_CODE_LEN = DefMaxCodeLen
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IdxW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  input  logic [IdxW-1:0]   entry_index_i,
  input  logic [SymW-1:0]   entry_symbol_i,
  input  logic [LenW-1:0]   entry_length_i,
  input  logic [CodeW-1:0]  entry_code_i,
  input  logic              code_bit_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              result_kind_o,
  output logic [SymW-1:0]   symbol_o
);

  localparam int unsigned PlenW = $clog2(MAX_CODE_LEN);
  localparam int unsigned XW    = (MAX_CODE_LEN > CodeW) ? MAX_CODE_LEN : CodeW;

  hbsd_state_e              state_q, state_d;
  logic [IdxW-1:0]          used_q;
  logic [PlenW-1:0]         plen_q, plen_d;
  logic [MAX_CODE_LEN-1:0]  pcode_q, pcode_d;
  logic                     err_q, err_d;
  logic                     bit_q;
  logic                     out_valid_q, out_valid_d;
  logic                     kind_q, kind_d;
  logic [SymW-1:0]          sym_q, sym_d;
  logic                     accept, out_free, out_wr, emit, root;
  hbsd_cmd_t                cmd;
  hbsd_load_t               load;
  hbsd_carry_t              res;
  logic [XW-1:0]            codex, lmask, shifted;
  logic [LenW:0]            shamt;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Path match of a newly loaded entry against the partial code so far.
  always_comb begin
    codex   = XW'(entry_code_i);
    lmask   = (XW'(entry_length_i) >= XW'(XW)) ? '1 : ((XW'(1) << entry_length_i) - 1'b1);
    shamt   = {1'b0, entry_length_i} - (LenW + 1)'(plen_q);
    shifted = (codex & lmask) >> shamt;
  end

  always_comb begin
    load.slot   = entry_index_i;
    load.symbol = entry_symbol_i;
    load.length = entry_length_i;
    load.code   = entry_code_i;
    load.alive  = ({1'b0, entry_length_i} >= (LenW + 1)'(plen_q)) &&
                  (shifted == XW'(pcode_q));
  end

  always_comb begin
    state_d = state_q;
    plen_d  = plen_q;
    pcode_d = pcode_q;
    err_d   = err_q;
    cmd     = '0;
    out_wr  = 1'b0;
    emit    = 1'b0;
    root    = 1'b0;
    kind_d  = KindSymbol;
    sym_d   = '0;
    cmd.code_bit = code_bit_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_LOAD: begin
              cmd.load = 1'b1;
            end
            OP_DECODE: begin
              if (!err_q) begin
                cmd.step = 1'b1;
                state_d  = ST_SCAN;
              end
            end
            OP_RESTART: begin
              cmd.restart = 1'b1;
              plen_d      = '0;
              pcode_d     = '0;
              err_d       = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!res.reach) begin
          emit   = 1'b1;
          root   = 1'b1;
          kind_d = KindError;
        end else if (res.exact && !res.ext) begin
          root  = 1'b1;
          emit  = (res.symbol != EndMarker);
          sym_d = res.symbol;
        end
        if (!emit || out_free) begin
          out_wr  = emit;
          state_d = ST_IDLE;
          if (root) begin
            plen_d      = '0;
            pcode_d     = '0;
            err_d       = !res.reach;
            cmd.restart = 1'b1;
          end else begin
            plen_d  = PlenW'(plen_q + 1'b1);
            pcode_d = {pcode_q[MAX_CODE_LEN-2:0], bit_q};
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_wr) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      plen_q      <= '0;
      pcode_q     <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      plen_q      <= plen_d;
      pcode_q     <= pcode_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        used_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.step) begin
      bit_q <= code_bit_i;
    end
    if (out_wr) begin
      kind_q <= kind_d;
      sym_q  <= sym_d;
    end
  end

  hbsd_row #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_row (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .load_i  (load),
    .plen_i  (plen_q),
    .used_i  (used_q),
    .scan_i  (state_q == ST_SCAN),
    .result_o(res)
  );

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign symbol_o      = sym_q;

endmodule

>>> test/tb_huffman_bit_serial_decoder.sv
// Self-checking testbench of the bit-serial Huffman decoder with a table-matching predictor.
`timescale 1ns / 1ps

module tb_huffman_bit_serial_decoder;
  import hbsd_pkg::*;

  localparam logic [1:0]  OpReserved   = 2'd3;
  localparam int unsigned TableSlots   = DefTableDepth;
  localparam int unsigned LongestCode  = DefMaxCodeLen;
  localparam int unsigned TotalItems   = 1650;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned SettleCycles = 8;

  typedef struct {
    logic [1:0]       op;
    logic [IdxW-1:0]  slot;
    logic [SymW-1:0]  symbol;
    logic [LenW-1:0]  length;
    logic [CodeW-1:0] code;
    logic             code_bit;
  } stream_item_t;

  typedef struct {
    logic            kind;
    logic [SymW-1:0] symbol;
  } decoded_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IdxW-1:0]  cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [1:0]       op_i;
  logic [IdxW-1:0]  entry_index_i;
  logic [SymW-1:0]  entry_symbol_i;
  logic [LenW-1:0]  entry_length_i;
  logic [CodeW-1:0] entry_code_i;
  logic             code_bit_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             result_kind_o;
  logic [SymW-1:0]  symbol_o;

  logic [SymW-1:0]  tab_symbol [TableSlots];
  logic [LenW-1:0]  tab_length [TableSlots];
  logic [CodeW-1:0] tab_code   [TableSlots];
  bit               tab_loaded [TableSlots];
  logic [63:0]      path_code;
  int unsigned      path_len;
  bit               path_error;
  int unsigned      active_entries;

  decoded_t         pending_symbols [$];
  logic [CodeW-1:0] set_code [$];
  logic [LenW-1:0]  set_len [$];
  logic [SymW-1:0]  set_sym [$];

  int unsigned      fail_count;
  int unsigned      counted_items;
  int unsigned      quiet_cycles;
  bit               sender_idles;
  bit               receiver_stalls;

  huffman_bit_serial_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .entry_index_i  (entry_index_i),
    .entry_symbol_i (entry_symbol_i),
    .entry_length_i (entry_length_i),
    .entry_code_i   (entry_code_i),
    .code_bit_i     (code_bit_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .symbol_o       (symbol_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] low_bits(input int unsigned n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned loaded_prefix();
    int unsigned k;
    k = 0;
    while (k < TableSlots && tab_loaded[IdxW'(k)]) k++;
    return k;
  endfunction

  task automatic advance_decoder(input stream_item_t it);
    int unsigned     plen;
    int unsigned     len;
    int unsigned     i;
    logic [63:0]     pcode;
    logic [63:0]     ecode;
    bit              reach;
    bit              ext;
    bit              exact;
    logic [SymW-1:0] hit;
    decoded_t        res;
    reach = 1'b0;
    ext   = 1'b0;
    exact = 1'b0;
    hit   = '0;
    case (it.op)
      OP_LOAD: begin
        tab_symbol[it.slot] = it.symbol;
        tab_length[it.slot] = it.length;
        tab_code[it.slot]   = it.code;
        tab_loaded[it.slot] = 1'b1;
      end
      OP_RESTART: begin
        path_code  = '0;
        path_len   = 0;
        path_error = 1'b0;
      end
      OP_DECODE: begin
        if (!path_error) begin
          plen  = path_len + 1;
          pcode = ((path_code << 1) | 64'(it.code_bit)) & low_bits(plen);
          for (i = 0; i < active_entries; i++) begin
            len = 32'(tab_length[IdxW'(i)]);
            if (len == 0 || len > LongestCode || len < plen) continue;
            ecode = 64'(tab_code[IdxW'(i)]) & low_bits(len);
            if ((ecode >> (len - plen)) != pcode) continue;
            reach = 1'b1;
            if (len == plen) begin
              if (!exact) begin
                exact = 1'b1;
                hit   = tab_symbol[IdxW'(i)];
              end
            end else begin
              ext = 1'b1;
            end
          end
          if (!reach) begin
            path_error = 1'b1;
            path_code  = '0;
            path_len   = 0;
            res.kind   = KindError;
            res.symbol = '0;
            pending_symbols.insert(pending_symbols.size(), res);
          end else if (exact && !ext) begin
            path_code = '0;
            path_len  = 0;
            if (hit != EndMarker) begin
              res.kind   = KindSymbol;
              res.symbol = hit;
              pending_symbols.insert(pending_symbols.size(), res);
            end
          end else begin
            path_code = pcode;
            path_len  = plen;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(input stream_item_t it);
    int unsigned gap;
    gap = sender_idles ? idle_length() : 0;
    repeat (gap) @(negedge clk_i);
    op_i           = it.op;
    entry_index_i  = it.slot;
    entry_symbol_i = it.symbol;
    entry_length_i = it.length;
    entry_code_i   = it.code;
    code_bit_i     = it.code_bit;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    advance_decoder(it);
    counted_items++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_load(input int unsigned slot, input logic [SymW-1:0] sym,
                           input logic [LenW-1:0] len, input logic [CodeW-1:0] code);
    stream_item_t it;
    it.op       = OP_LOAD;
    it.slot     = IdxW'(slot);
    it.symbol   = sym;
    it.length   = len;
    it.code     = code;
    it.code_bit = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  task automatic send_other(input logic [1:0] op, input logic bit_value);
    stream_item_t it;
    it.op       = op;
    it.slot     = IdxW'($urandom);
    it.symbol   = SymW'($urandom);
    it.length   = LenW'($urandom);
    it.code     = $urandom;
    it.code_bit = bit_value;
    send_item(it);
  endtask

  task automatic send_code(input logic [CodeW-1:0] code, input int unsigned len);
    int b;
    for (b = int'(len) - 1; b >= 0; b--) send_other(OP_DECODE, code[b[CodeIdxW-1:0]]);
  endtask

  task automatic wait_drained();
    while (pending_symbols.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_entries(input int unsigned count);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = IdxW'(count);
    @(posedge clk_i);
    active_entries = count;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic split_leaf(input int unsigned pick);
    logic [CodeW-1:0] c;
    logic [LenW-1:0]  l;
    c = set_code[pick];
    l = set_len[pick];
    set_code[pick] = c << 1;
    set_len[pick]  = l + 6'd1;
    set_code.insert(set_code.size(), (c << 1) | CodeW'(1));
    set_len.insert(set_len.size(), l + 6'd1);
  endtask

  task automatic run_code_phase(input bit full);
    int unsigned      target;
    int unsigned      pick;
    int unsigned      rounds;
    int unsigned      n;
    int unsigned      e;
    int unsigned      r;
    int unsigned      count;
    logic [CodeW-1:0] junk;
    set_code.delete();
    set_len.delete();
    set_sym.delete();
    set_code.insert(set_code.size(), CodeW'(0));
    set_len.insert(set_len.size(), LenW'(1));
    set_code.insert(set_code.size(), CodeW'(1));
    set_len.insert(set_len.size(), LenW'(1));
    target = full ? TableSlots : $urandom_range(2, 12);
    while (set_code.size() < target) begin
      pick = $urandom_range(0, set_code.size() - 1);
      if (set_len[pick] < LongestCode) split_leaf(pick);
    end
    if (!full) begin
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, set_code.size() - 1);
        while (set_len[pick] < LongestCode) split_leaf(pick);
      end
      if ($urandom_range(0, 2) == 0 && set_code.size() > 2) begin
        pick = $urandom_range(1, set_code.size() - 1);
        set_code.delete(pick);
        set_len.delete(pick);
      end
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, set_code.size() - 1);
        if (set_len[pick] >= 2) begin
          set_code.insert(set_code.size(), set_code[pick] >> 1);
          set_len.insert(set_len.size(), set_len[pick] - 6'd1);
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, set_code.size() - 1);
        set_code.insert(set_code.size(), set_code[pick]);
        set_len.insert(set_len.size(), set_len[pick]);
      end
      if ($urandom_range(0, 2) == 0) begin
        set_code.insert(set_code.size(), $urandom);
        set_len.insert(set_len.size(),
                       ($urandom_range(0, 1) == 0) ? 6'd0 : LenW'($urandom_range(33, 63)));
      end
    end
    for (e = 0; e < set_code.size(); e++) begin
      set_sym.insert(set_sym.size(),
                     ($urandom_range(0, 9) == 0) ? EndMarker : SymW'($urandom_range(0, 255)));
      junk = CodeW'($urandom) << set_len[e];
      send_load(e, set_sym[e], set_len[e], set_code[e] | junk);
    end
    if (!full && $urandom_range(0, 3) == 0) begin
      send_load($urandom_range(set_code.size(), TableSlots - 1), SymW'($urandom),
                LenW'($urandom_range(0, 63)), $urandom);
    end
    count = set_code.size();
    if (!full && $urandom_range(0, 4) == 0) count = $urandom_range(0, loaded_prefix());
    if (count > TableSlots - 1) count = TableSlots - 1;
    set_entries(count);
    send_other(OP_RESTART, 1'($urandom_range(0, 1)));
    rounds = full ? 60 : $urandom_range(10, 40);
    for (n = 0; n < rounds; n++) begin
      r = $urandom_range(0, 99);
      if (path_error && r < 80) begin
        send_other(OP_RESTART, 1'($urandom_range(0, 1)));
      end else if (r < 85) begin
        e = $urandom_range(0, set_code.size() - 1);
        if (set_len[e] == 0 || set_len[e] > LongestCode) e = 0;
        send_code(set_code[e], 32'(set_len[e]));
      end else if (r < 91) begin
        send_other(OP_DECODE, 1'($urandom_range(0, 1)));
      end else if (r < 95) begin
        send_other(OP_RESTART, 1'($urandom_range(0, 1)));
      end else if (r < 97) begin
        send_other(OpReserved, 1'($urandom_range(0, 1)));
      end else begin
        send_load($urandom_range(0, TableSlots - 1), SymW'($urandom),
                  LenW'($urandom_range(0, 63)), $urandom);
      end
    end
  endtask

  task automatic test_empty_table();
    set_entries(0);
    send_other(OP_DECODE, 1'b1);
    send_load(0, 8'h41, 6'd1, 32'h0000_0000);
    send_other(OP_DECODE, 1'b0);
    send_other(OpReserved, 1'b1);
    send_other(OP_RESTART, 1'b0);
  endtask

  task automatic test_table_cases();
    send_load(0, 8'h41, 6'd1, 32'hFFFF_FFFE);
    send_load(1, EndMarker, 6'd2, 32'h0000_0002);
    send_load(2, 8'hFF, 6'd3, 32'h0000_0006);
    send_load(3, 8'h55, 6'd3, 32'hFFFF_FFFE);
    send_load(4, 8'h77, 6'd0, 32'h0000_0000);
    send_load(5, 8'h66, 6'd63, 32'hFFFF_FFFF);
    send_load(6, 8'h22, 6'd32, 32'hFFFF_FFFF);
    send_load(7, 8'h33, 6'd2, 32'h0000_0003);
    set_entries(8);
    send_code(32'h0, 1);
    send_code(32'h2, 2);
    send_code(32'h6, 3);
    send_other(OP_DECODE, 1'b1);
    send_load(9, 8'h99, 6'd5, 32'h0000_001F);
    send_code(32'h2, 2);
    send_code(32'hE, 4);
    send_other(OP_DECODE, 1'b1);
    send_other(OP_RESTART, 1'b1);
  endtask

  task automatic test_full_table();
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    run_code_phase(1'b1);
  endtask

  task automatic test_random_streams();
    while (counted_items < TotalItems) begin
      sender_idles    = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      run_code_phase(1'b0);
    end
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_symbols.size() == 0) begin
        $error("unexpected result: result_kind %0d symbol %0h", result_kind_o, symbol_o);
        fail_count++;
      end else begin
        want = pending_symbols.pop_front();
        if (result_kind_o !== want.kind) begin
          $error("result_kind expected %0d actual %0d", want.kind, result_kind_o);
          fail_count++;
        end
        if (symbol_o !== want.symbol) begin
          $error("symbol expected %0h actual %0h", want.symbol, symbol_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned run_left;
    int unsigned hold_left;
    run_left    = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!receiver_stalls) begin
        out_stall_i = 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else if (run_left != 0) begin
        run_left--;
        out_stall_i = 1'b0;
      end else begin
        run_left    = $urandom_range(0, 6);
        hold_left   = idle_length();
        out_stall_i = 1'b0;
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    wait (rst_ni === 1'b1);
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("huffman_bit_serial_decoder test failed");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    op_i            = OP_LOAD;
    entry_index_i   = '0;
    entry_symbol_i  = '0;
    entry_length_i  = '0;
    entry_code_i    = '0;
    code_bit_i      = 1'b0;
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    fail_count      = 0;
    counted_items   = 0;
    path_code       = '0;
    path_len        = 0;
    path_error      = 1'b0;
    active_entries  = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_table();
    test_table_cases();
    test_full_table();
    test_random_streams();
    wait_drained();
    if (fail_count == 0) begin
      $display("huffman_bit_serial_decoder test passed");
    end else begin
      $display("huffman_bit_serial_decoder test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/hbsd_pkg.sv
hw/rtl/hbsd_cell.sv
hw/rtl/hbsd_row.sv
hw/rtl/huffman_bit_serial_decoder.sv
test/tb_huffman_bit_serial_decoder.sv
